>>> design/rpnc_pkg.sv
// ----------------------------------------------------------------------------
// rpnc_pkg
// Shared types and codes for the reverse-Polish stack calculator.
// ----------------------------------------------------------------------------
package rpnc_pkg;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int DEPTH_W  = 3;

	// Action codes carried on the input tuser.
	localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DIV  = 3'd4;

	// Status codes carried on the output tuser.
	localparam logic [STATUS_W-1:0] ST_PUSHED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OPDONE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_ADDSUB,
		A_MUL,
		A_NEG_A,
		A_NEG_B,
		A_DIV,
		A_FIX,
		A_DONE
	} alu_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_DECODE,
		T_START,
		T_WAIT,
		T_RESULT
	} top_state_t;

endpackage

>>> design/rpnc_alu.sv
// ----------------------------------------------------------------------------
// rpnc_alu
// Iterative arithmetic unit built around one adder: add and subtract in one
// pass, shift-and-add multiply and restoring divide one bit per cycle.
// ----------------------------------------------------------------------------
module rpnc_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rpnc_pkg::alu_req_t       req,
	input  logic [DATA_WIDTH-1:0]    a,
	input  logic [DATA_WIDTH-1:0]    b,
	output logic                     done,
	output logic [DATA_WIDTH-1:0]    result
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(DATA_WIDTH);

	rpnc_pkg::alu_state_t state_q, state_d;
	rpnc_pkg::alu_op_t    op_q, op_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [W-1:0]         x_q, x_d;
	logic [W-1:0]         y_q, y_d;
	logic [W-1:0]         acc_q, acc_d;
	logic                 neg_q, neg_d;

	logic [W:0]           add_x, add_y;
	logic                 add_cin;
	logic [W+1:0]         sum;
	logic [W:0]           div_t;
	logic                 carry;

	// The one shared adder.
	assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};
	assign div_t = {acc_q, x_q[W-1]};
	assign carry = sum[W+1];

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		x_d     = x_q;
		y_d     = y_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			rpnc_pkg::A_IDLE: begin
				if (req.start) begin
					x_d   = a;
					y_d   = b;
					acc_d = '0;
					cnt_d = '0;
					op_d  = req.op;
					neg_d = a[W-1] ^ b[W-1];
					unique case (req.op)
						rpnc_pkg::ALU_ADD, rpnc_pkg::ALU_SUB: state_d = rpnc_pkg::A_ADDSUB;
						rpnc_pkg::ALU_MUL: state_d = rpnc_pkg::A_MUL;
						rpnc_pkg::ALU_DIV: state_d = rpnc_pkg::A_NEG_A;
					endcase
				end
			end
			rpnc_pkg::A_ADDSUB: begin
				add_x = {1'b0, x_q};
				if (op_q == rpnc_pkg::ALU_SUB) begin
					add_y   = {1'b0, ~y_q};
					add_cin = 1'b1;
				end else begin
					add_y = {1'b0, y_q};
				end
				acc_d   = sum[W-1:0];
				state_d = rpnc_pkg::A_DONE;
			end
			rpnc_pkg::A_MUL: begin
				// Partial products accumulate modulo the word width.
				add_x = {1'b0, acc_q};
				add_y = y_q[0] ? {1'b0, x_q} : '0;
				acc_d = sum[W-1:0];
				x_d   = {x_q[W-2:0], 1'b0};
				y_d   = {1'b0, y_q[W-1:1]};
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1))
					state_d = rpnc_pkg::A_DONE;
			end
			rpnc_pkg::A_NEG_A: begin
				add_y   = {1'b0, ~x_q};
				add_cin = 1'b1;
				if (x_q[W-1])
					x_d = sum[W-1:0];
				state_d = rpnc_pkg::A_NEG_B;
			end
			rpnc_pkg::A_NEG_B: begin
				add_y   = {1'b0, ~y_q};
				add_cin = 1'b1;
				if (y_q[W-1])
					y_d = sum[W-1:0];
				state_d = rpnc_pkg::A_DIV;
			end
			rpnc_pkg::A_DIV: begin
				// Trial subtraction; the carry out says the divisor fitted.
				add_x   = div_t;
				add_y   = ~{1'b0, y_q};
				add_cin = 1'b1;
				acc_d   = carry ? sum[W-1:0] : div_t[W-1:0];
				x_d     = {x_q[W-2:0], carry};
				cnt_d   = cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1))
					state_d = rpnc_pkg::A_FIX;
			end
			rpnc_pkg::A_FIX: begin
				add_y   = {1'b0, ~x_q};
				add_cin = 1'b1;
				acc_d   = neg_q ? sum[W-1:0] : x_q;
				state_d = rpnc_pkg::A_DONE;
			end
			rpnc_pkg::A_DONE: begin
				done    = 1'b1;
				state_d = rpnc_pkg::A_IDLE;
			end
			default: state_d = rpnc_pkg::A_IDLE;
		endcase
	end

	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpnc_pkg::A_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		x_q   <= x_d;
		y_q   <= y_d;
		acc_q <= acc_d;
		neg_q <= neg_d;
	end

endmodule

>>> design/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse-Polish integer calculator on a small stack with an iterative ALU.
// ----------------------------------------------------------------------------
// One word is taken at a time and its result word is produced before the next
// is accepted. A push, a refused push, a divide by zero or an unused action is
// settled in the decode state and goes straight to the result state; add,
// subtract, multiply and divide go through the ALU start and wait states. The
// shared ALU runs multiply and divide one bit per cycle through its single
// adder. A new word can be accepted while the previous result still waits in
// the output register.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 4,
	parameter int DATA_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] operand_value
	input  logic [2:0]  s_tuser,   // [2:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] top_value, [34:32] stack_depth, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);

	rpnc_pkg::top_state_t state_q, state_d;
	logic [DW-1:0]        depth_q, depth_d;
	logic [DATA_WIDTH-1:0] top_q, top_d;
	logic [rpnc_pkg::STATUS_W-1:0] status_q, status_d;
	logic [rpnc_pkg::ACTION_W-1:0] act_q;
	logic [31:0]          val_q;

	logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	logic [DW-1:0]        pop_idx, zd_idx;
	logic [DATA_WIDTH-1:0] push_val;
	logic [31:0]          top_out;
	logic [DW+2:0]        depth_ext;

	rpnc_pkg::alu_req_t   alu_req;
	rpnc_pkg::alu_op_t    alu_op;
	logic                 alu_done;
	logic [DATA_WIDTH-1:0] alu_result;
	logic [DATA_WIDTH-1:0] alu_left;

	logic                 m_tvalid_q;
	logic                 out_load;
	logic [31:0]          out_top_q;
	logic [2:0]           out_depth_q;
	logic [1:0]           out_status_q;

	generate
		if (DATA_WIDTH > 32) begin : g_push_wide
			assign push_val = {{(DATA_WIDTH - 32){val_q[31]}}, val_q};
		end else begin : g_push_narrow
			assign push_val = val_q[DATA_WIDTH-1:0];
		end
		if (DATA_WIDTH >= 32) begin : g_top_wide
			assign top_out = top_q[31:0];
		end else begin : g_top_narrow
			assign top_out = {{(32 - DATA_WIDTH){1'b0}}, top_q};
		end
	endgenerate

	assign depth_ext = {3'b000, depth_q};

	// Index of the left operand, which is also where the result lands.
	assign pop_idx = (depth_q >= DW'(2)) ? depth_q - DW'(2) : '0;
	assign zd_idx  = (depth_q != '0) ? depth_q - DW'(1) : '0;

	// The top entry lives in top_q, so only the left operand needs a read.
	assign alu_left = (depth_q >= DW'(2)) ? rd_data_q : '0;

	always_comb begin
		unique case (act_q)
			rpnc_pkg::ACT_SUB: alu_op = rpnc_pkg::ALU_SUB;
			rpnc_pkg::ACT_MUL: alu_op = rpnc_pkg::ALU_MUL;
			rpnc_pkg::ACT_DIV: alu_op = rpnc_pkg::ALU_DIV;
			default:           alu_op = rpnc_pkg::ALU_ADD;
		endcase
	end

	always_comb begin
		state_d       = state_q;
		depth_d       = depth_q;
		top_d         = top_q;
		status_d      = status_q;
		wr_en         = 1'b0;
		wr_addr       = pop_idx[AW-1:0];
		wr_data       = alu_result;
		alu_req.start = 1'b0;
		alu_req.op    = alu_op;
		out_load      = 1'b0;
		s_tready      = 1'b0;
		unique case (state_q)
			rpnc_pkg::T_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = rpnc_pkg::T_DECODE;
			end
			rpnc_pkg::T_DECODE: begin
				unique case (act_q)
					rpnc_pkg::ACT_PUSH: begin
						if (depth_q == DW'(STACK_DEPTH)) begin
							status_d = rpnc_pkg::ST_FULL;
						end else begin
							wr_en    = 1'b1;
							wr_addr  = depth_q[AW-1:0];
							wr_data  = push_val;
							top_d    = push_val;
							depth_d  = depth_q + DW'(1);
							status_d = rpnc_pkg::ST_PUSHED;
						end
						state_d = rpnc_pkg::T_RESULT;
					end
					rpnc_pkg::ACT_ADD, rpnc_pkg::ACT_SUB, rpnc_pkg::ACT_MUL: begin
						state_d = rpnc_pkg::T_START;
					end
					rpnc_pkg::ACT_DIV: begin
						// A zero divisor goes back where it was; on an empty
						// stack that leaves a single zero.
						if (top_q == '0) begin
							wr_en    = 1'b1;
							wr_addr  = zd_idx[AW-1:0];
							wr_data  = '0;
							top_d    = '0;
							depth_d  = (depth_q == '0) ? DW'(1) : depth_q;
							status_d = rpnc_pkg::ST_DIVZERO;
							state_d  = rpnc_pkg::T_RESULT;
						end else begin
							state_d = rpnc_pkg::T_START;
						end
					end
					default: begin
						status_d = rpnc_pkg::ST_OPDONE;
						state_d  = rpnc_pkg::T_RESULT;
					end
				endcase
			end
			rpnc_pkg::T_START: begin
				alu_req.start = 1'b1;
				state_d       = rpnc_pkg::T_WAIT;
			end
			rpnc_pkg::T_WAIT: begin
				if (alu_done) begin
					wr_en    = 1'b1;
					wr_addr  = pop_idx[AW-1:0];
					wr_data  = alu_result;
					top_d    = alu_result;
					depth_d  = pop_idx + DW'(1);
					status_d = rpnc_pkg::ST_OPDONE;
					state_d  = rpnc_pkg::T_RESULT;
				end
			end
			rpnc_pkg::T_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = rpnc_pkg::T_IDLE;
				end
			end
			default: state_d = rpnc_pkg::T_IDLE;
		endcase
	end

	rpnc_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_left),
		.b      (top_q),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[wr_addr] <= wr_data;
		rd_data_q <= stack_mem[pop_idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rpnc_pkg::T_IDLE;
			depth_q    <= '0;
			top_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			top_q   <= top_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		if (s_tvalid && s_tready) begin
			act_q <= s_tuser;
			val_q <= s_tdata;
		end
		if (out_load) begin
			out_top_q    <= top_out;
			out_depth_q  <= depth_ext[2:0];
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, out_depth_q, out_top_q};
	assign m_tuser  = out_status_q;

endmodule
